@@ design/matrix_inverse_3x3_macros.svh @@
// Assertion macros used by the port-level checker of the 3x3 inverse.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef MATRIX_INVERSE_3X3_MACROS_SVH
`define MATRIX_INVERSE_3X3_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MINV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MINV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ design/minv_pkg.sv @@
// Package of the 3x3 fixed-point matrix inverse: widths, word types and
// pipeline structs. No dependencies.
package minv_pkg;

	localparam int EW    = 32;          // element width
	localparam int FB    = 16;          // fraction bits
	localparam int CW    = 2 * EW + 1;  // signed cofactor width
	localparam int CMW   = 2 * EW;      // cofactor magnitude width
	localparam int DW    = 3 * EW + 3;  // signed determinant width
	localparam int DMW   = DW - 1;      // determinant magnitude width
	localparam int NW    = CMW + 2 * FB; // scaled numerator width
	localparam int PW    = DMW + EW;    // width of the range pre-check
	localparam int NLANE = 9;

	typedef logic signed [EW-1:0]   elem_t;
	typedef logic signed [2*EW-1:0] prod_t;
	typedef logic signed [CW-1:0]   cof_t;
	typedef logic [CMW-1:0]         cmag_t;
	typedef logic [DMW-1:0]         dmag_t;

	typedef struct packed {
		elem_t m00; elem_t m01; elem_t m02;
		elem_t m10; elem_t m11; elem_t m12;
		elem_t m20; elem_t m21; elem_t m22;
	} mat_t;

	typedef struct packed {
		elem_t r00; elem_t r01; elem_t r02;
		elem_t r10; elem_t r11; elem_t r12;
		elem_t r20; elem_t r21; elem_t r22;
		logic  singular;
		logic  saturated;
	} res_t;

	// One quotient lane of the restoring divider.
	typedef struct packed {
		dmag_t         rem;
		logic [EW-1:0] nlo;  // numerator bits still to shift in
		logic [EW-1:0] q;
		logic          neg;
		logic          sat;  // quotient known to exceed the element range
	} lane_t;

	typedef struct packed {
		logic  zero;
		dmag_t dmag;
		lane_t [NLANE-1:0] lane;
	} div_t;

endpackage

@@ design/minv_in_if.sv @@
// Input channel of the 3x3 inverse: one matrix word per handshake.
// Depends on minv_pkg.
interface minv_in_if;
	import minv_pkg::*;
	logic valid;
	logic ready;
	mat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/minv_out_if.sv @@
// Output channel of the 3x3 inverse: one result word per handshake.
// Depends on minv_pkg.
interface minv_out_if;
	import minv_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/minv_cof.sv @@
// Cofactor stages: eighteen element products, then the nine 2x2 cofactors.
// Depends on minv_pkg.
module minv_cof (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  minv_pkg::mat_t   mat,
	output logic             valid_s2,
	output minv_pkg::cof_t   cof_s2 [9],
	output minv_pkg::elem_t  row0_s2 [3]
);
	import minv_pkg::*;

	localparam logic [3:0] IA [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
	localparam logic [3:0] IB [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
	localparam logic [3:0] IC [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
	localparam logic [3:0] ID [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

	elem_t m [9];
	prod_t pa_s1 [9];
	prod_t pb_s1 [9];
	elem_t row0_s1 [3];
	logic  valid_s1;

	assign m[0] = mat.m00;
	assign m[1] = mat.m01;
	assign m[2] = mat.m02;
	assign m[3] = mat.m10;
	assign m[4] = mat.m11;
	assign m[5] = mat.m12;
	assign m[6] = mat.m20;
	assign m[7] = mat.m21;
	assign m[8] = mat.m22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				pa_s1[i]  <= m[IA[i]] * m[IB[i]];
				pb_s1[i]  <= m[IC[i]] * m[ID[i]];
				cof_s2[i] <= CW'(pa_s1[i]) - CW'(pb_s1[i]);
			end
			for (int k = 0; k < 3; k++) begin
				row0_s1[k] <= m[k];
				row0_s2[k] <= row0_s1[k];
			end
		end
	end

endmodule

@@ design/minv_det.sv @@
// Determinant stages: split products of row 0 with its cofactors, their sum,
// magnitudes, and the setup of the divider lanes. Depends on minv_pkg.
module minv_det (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_s2,
	input  minv_pkg::cof_t  cof_s2 [9],
	input  minv_pkg::elem_t row0_s2 [3],
	output logic            valid_s7,
	output minv_pkg::div_t  item_s7
);
	import minv_pkg::*;

	logic signed [2*EW:0] plo_s3 [3];
	logic signed [2*EW:0] phi_s3 [3];
	logic signed [DW-1:0] term_s4 [3];
	logic signed [DW-1:0] det_s5;
	cof_t  cof_s3 [9];
	cof_t  cof_s4 [9];
	cof_t  cof_s5 [9];
	logic  valid_s3, valid_s4, valid_s5, valid_s6;

	logic  zero_s6, dneg_s6;
	dmag_t dmag_s6;
	cmag_t cmag_s6 [9];
	logic  cneg_s6 [9];

	logic signed [DW-1:0] dabs;
	cof_t  cabs [9];
	div_t  item_d;
	logic [NW-1:0] num;
	logic [PW-1:0] nwide, dwide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_comb begin
		dabs = det_s5[DW-1] ? -det_s5 : det_s5;
		for (int i = 0; i < 9; i++)
			cabs[i] = cof_s5[i][CW-1] ? -cof_s5[i] : cof_s5[i];
	end

	// Lane setup: a quotient of 2^EW or more is caught up front by comparing
	// the scaled numerator against the divisor moved up by EW bits.
	always_comb begin
		item_d.zero = zero_s6;
		item_d.dmag = dmag_s6;
		dwide = PW'(dmag_s6) << EW;
		for (int i = 0; i < NLANE; i++) begin
			num   = {cmag_s6[i], {(2 * FB){1'b0}}};
			nwide = PW'(num);
			item_d.lane[i].sat = nwide >= dwide;
			item_d.lane[i].rem = DMW'(num >> EW);
			item_d.lane[i].nlo = num[EW-1:0];
			item_d.lane[i].q   = '0;
			item_d.lane[i].neg = cneg_s6[i] ^ dneg_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				plo_s3[k]  <= row0_s2[k] * $signed({1'b0, cof_s2[3*k][EW-1:0]});
				phi_s3[k]  <= row0_s2[k] * $signed(cof_s2[3*k][CW-1:EW]);
				term_s4[k] <= (DW'(phi_s3[k]) <<< EW) + DW'(plo_s3[k]);
			end
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			for (int i = 0; i < 9; i++) begin
				cof_s3[i]  <= cof_s2[i];
				cof_s4[i]  <= cof_s3[i];
				cof_s5[i]  <= cof_s4[i];
				cmag_s6[i] <= cabs[i][CMW-1:0];
				cneg_s6[i] <= cof_s5[i][CW-1];
			end
			zero_s6 <= det_s5 == '0;
			dneg_s6 <= det_s5[DW-1];
			dmag_s6 <= dabs[DMW-1:0];
			item_s7 <= item_d;
		end
	end

endmodule

@@ design/minv_div_step.sv @@
// One stage of the restoring divider: one quotient bit for each of the nine
// lanes against the shared divisor. Depends on minv_pkg.
module minv_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  minv_pkg::div_t in_item,
	output logic           out_valid,
	output minv_pkg::div_t out_item
);
	import minv_pkg::*;

	div_t         nxt;
	logic [DMW:0] trial;
	logic [DMW:0] diff;
	logic         ge;

	always_comb begin
		nxt = in_item;
		for (int i = 0; i < NLANE; i++) begin
			trial = {in_item.lane[i].rem, in_item.lane[i].nlo[EW-1]};
			diff  = trial - {1'b0, in_item.dmag};
			ge    = trial >= {1'b0, in_item.dmag};
			nxt.lane[i].rem = ge ? diff[DMW-1:0] : trial[DMW-1:0];
			nxt.lane[i].nlo = in_item.lane[i].nlo << 1;
			nxt.lane[i].q   = {in_item.lane[i].q[EW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			out_item <= nxt;
	end

endmodule

@@ design/minv_out.sv @@
// Output stage: sign, saturation and the singular case, then a two-word
// queue whose head drives the output channel. Depends on minv_pkg.
module minv_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  minv_pkg::div_t    item,
	output logic              en,
	minv_out_if.source        out_ch
);
	import minv_pkg::*;

	localparam elem_t MAXV = {1'b0, {(EW - 1){1'b1}}};
	localparam elem_t MINV = {1'b1, {(EW - 1){1'b0}}};
	localparam logic [EW-1:0] HALF = {1'b1, {(EW - 1){1'b0}}};

	elem_t r [9];
	logic  sat_any;
	res_t  fmt;
	res_t  head_q, tail_q;
	logic [1:0] cnt_q;
	logic  push, pop;

	always_comb begin
		sat_any = 1'b0;
		for (int i = 0; i < NLANE; i++) begin
			if (item.lane[i].sat) begin
				r[i] = item.lane[i].neg ? MINV : MAXV;
				sat_any = 1'b1;
			end else if (item.lane[i].neg) begin
				if (item.lane[i].q > HALF) begin
					r[i] = MINV;
					sat_any = 1'b1;
				end else begin
					r[i] = -$signed(item.lane[i].q);
				end
			end else if (item.lane[i].q[EW-1]) begin
				r[i] = MAXV;
				sat_any = 1'b1;
			end else begin
				r[i] = $signed(item.lane[i].q);
			end
		end
		if (item.zero) begin
			for (int i = 0; i < NLANE; i++)
				r[i] = '0;
			sat_any = 1'b0;
		end
		fmt.r00 = r[0]; fmt.r01 = r[1]; fmt.r02 = r[2];
		fmt.r10 = r[3]; fmt.r11 = r[4]; fmt.r12 = r[5];
		fmt.r20 = r[6]; fmt.r21 = r[7]; fmt.r22 = r[8];
		fmt.singular  = item.zero;
		fmt.saturated = sat_any;
	end

	// The pipeline moves only while the queue has a free slot.
	assign en   = cnt_q != 2'd2;
	assign push = in_valid && en;
	assign pop  = out_ch.valid && out_ch.ready;

	assign out_ch.valid = cnt_q != 2'd0;
	assign out_ch.data  = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (push && !pop)
			cnt_q <= cnt_q + 2'd1;
		else if (pop && !push)
			cnt_q <= cnt_q - 2'd1;
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (cnt_q == 2'd0)
				head_q <= fmt;
			else
				tail_q <= fmt;
		end else if (pop && !push) begin
			head_q <= tail_q;
		end else if (push && pop) begin
			head_q <= fmt;
		end
	end

endmodule

@@ design/matrix_inverse_3x3.sv @@
// Top level of the pipelined 3x3 fixed-point matrix inverse by the adjugate.
// Depends on minv_pkg, the channel interfaces and the minv_* stage modules.
//
//   Channel | Direction | Word                                   | Handshake
//   in_ch   | in        | nine signed Q16.16 elements m00..m22   | valid/ready
//   out_ch  | out       | r00..r22, singular, saturated          | valid/ready
//
// One matrix word can be taken every cycle while the output queue has a free
// slot. The pipeline depth is set mostly by the divider, which resolves one
// quotient bit per stage for all nine lanes at once. Reset clears every valid
// bit and the output queue; the data registers are not reset. When the output
// is stalled the queue behind it absorbs one more word before the whole
// pipeline holds, so nothing is lost or repeated.
module matrix_inverse_3x3 (
	input  logic       clk,
	input  logic       arst_n,
	minv_in_if.sink    in_ch,
	minv_out_if.source out_ch
);
	import minv_pkg::*;

	// Stage map: s1 products, s2 cofactors, s3 split determinant products,
	// s4 partial terms, s5 determinant, s6 magnitudes, s7 lane setup, then
	// one register stage per quotient bit and finally the output queue.
	logic  en;
	logic  valid_s2;
	cof_t  cof_s2 [9];
	elem_t row0_s2 [3];
	logic  dv_valid [EW+1];
	div_t  dv_item [EW+1];

	// Input is taken whenever the pipeline advances.
	assign in_ch.ready = en;

	minv_cof u_cof (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_ch.valid),
		.mat      (in_ch.data),
		.valid_s2 (valid_s2),
		.cof_s2   (cof_s2),
		.row0_s2  (row0_s2)
	);

	minv_det u_det (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.cof_s2   (cof_s2),
		.row0_s2  (row0_s2),
		.valid_s7 (dv_valid[0]),
		.item_s7  (dv_item[0])
	);

	// Divider chain: stage i produces quotient bit EW-1-i of every lane.
	for (genvar i = 0; i < EW; i++) begin : g_div
		minv_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv_valid[i]),
			.in_item   (dv_item[i]),
			.out_valid (dv_valid[i+1]),
			.out_item  (dv_item[i+1])
		);
	end

	minv_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv_valid[EW]),
		.item     (dv_item[EW]),
		.en       (en),
		.out_ch   (out_ch)
	);

endmodule

@@ design/minv_checker.sv @@
// Port-level checks of the 3x3 inverse, bound to the top level.
// Depends on minv_pkg and matrix_inverse_3x3_macros.svh.
`include "matrix_inverse_3x3_macros.svh"

module minv_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input minv_pkg::res_t out_data
);
	import minv_pkg::*;

	logic all_zero;
	assign all_zero = out_data.r00 == '0 && out_data.r01 == '0 && out_data.r02 == '0 &&
		out_data.r10 == '0 && out_data.r11 == '0 && out_data.r12 == '0 &&
		out_data.r20 == '0 && out_data.r21 == '0 && out_data.r22 == '0;

	// A word that waits must still be offered in the next cycle.
	`MINV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// A singular matrix never reports saturation.
	`MINV_ASSERT_NOW(a_sing_nosat, out_valid && out_data.singular, !out_data.saturated)
	// A singular matrix returns all zeros.
	`MINV_ASSERT_NOW(a_sing_zero, out_valid && out_data.singular, all_zero)
	// Input is refused only while a result waits at the output.
	`MINV_ASSERT_NOW(a_stall_cause, !in_ready, out_valid)

endmodule

bind matrix_inverse_3x3 minv_checker u_minv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

@@ tb/testbench.sv @@
// Self-checking testbench of the 3x3 fixed-point matrix inverse.
// Depends on minv_pkg, minv_in_if, minv_out_if and matrix_inverse_3x3.
`timescale 1ns / 100ps

module testbench;
	import minv_pkg::*;

	localparam int N_RANDOM  = 1530;
	localparam int DRAIN_CYC = 2 * EW + 16;
	localparam int HOLD_CYC  = 400;

	// One row of the directed table. Where has_exp is set the expected inverse
	// is typed in; otherwise the predictor supplies it.
	typedef struct {
		mat_t m;
		bit   has_exp;
		res_t r;
	} vec_row_t;

	logic clk;
	logic arst_n;

	minv_in_if  in_ch ();
	minv_out_if out_ch ();

	matrix_inverse_3x3 uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	res_t     inverse_fifo[$];
	vec_row_t vec_table[$];
	int       errors = 0;
	int       words_in = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       hold_left = 0;
	bit       hold_done = 0;

	localparam elem_t ONE  = 32'sh0001_0000;
	localparam elem_t EMAX = 32'sh7fff_ffff;
	localparam elem_t EMIN = -32'sh8000_0000;
	localparam elem_t EZERO = 32'sh0000_0000;
	localparam elem_t EUNIT = 32'sh0000_0001;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous fixed limit on the whole run.
	initial begin
		#5ms;
		$display("matrix_inverse_3x3 regression: fail");
		$finish;
	end

	function automatic logic signed [255:0] cof2(logic signed [255:0] a, logic signed [255:0] b,
			logic signed [255:0] c, logic signed [255:0] d);
		return a * b - c * d;
	endfunction

	// Exact inverse by the adjugate: every cofactor and the determinant are held
	// in 256 bits, each quotient truncates toward zero and then clamps.
	function automatic res_t invert_q16(mat_t m);
		logic signed [255:0] e[9];
		logic signed [255:0] adj[9];
		logic signed [255:0] det;
		logic [255:0] num, dmag, q;
		logic [255:0] lim;
		elem_t v[9];
		logic sat;
		bit neg;
		res_t r;
		e[0] = m.m00; e[1] = m.m01; e[2] = m.m02;
		e[3] = m.m10; e[4] = m.m11; e[5] = m.m12;
		e[6] = m.m20; e[7] = m.m21; e[8] = m.m22;
		adj[0] = cof2(e[4], e[8], e[5], e[7]);
		adj[3] = cof2(e[5], e[6], e[3], e[8]);
		adj[6] = cof2(e[3], e[7], e[4], e[6]);
		adj[1] = cof2(e[2], e[7], e[1], e[8]);
		adj[4] = cof2(e[0], e[8], e[2], e[6]);
		adj[7] = cof2(e[1], e[6], e[0], e[7]);
		adj[2] = cof2(e[1], e[5], e[2], e[4]);
		adj[5] = cof2(e[2], e[3], e[0], e[5]);
		adj[8] = cof2(e[0], e[4], e[1], e[3]);
		det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
		lim = 256'd1 << (EW - 1);
		sat = 1'b0;
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		dmag = (det < 0) ? -det : det;
		for (int i = 0; i < 9; i++) begin
			neg = (adj[i] < 0) != (det < 0);
			num = ((adj[i] < 0) ? -adj[i] : adj[i]) << (2 * FB);
			q = num / dmag;
			if (neg) begin
				if (q > lim) begin
					v[i] = EMIN;
					sat = 1'b1;
				end else begin
					v[i] = -q[EW-1:0];
				end
			end else begin
				if (q >= lim) begin
					v[i] = EMAX;
					sat = 1'b1;
				end else begin
					v[i] = q[EW-1:0];
				end
			end
		end
		r.r00 = v[0]; r.r01 = v[1]; r.r02 = v[2];
		r.r10 = v[3]; r.r11 = v[4]; r.r12 = v[5];
		r.r20 = v[6]; r.r21 = v[7]; r.r22 = v[8];
		r.saturated = sat;
		return r;
	endfunction

	function automatic mat_t diag(elem_t a, elem_t b, elem_t c);
		mat_t m;
		m = '0;
		m.m00 = a; m.m11 = b; m.m22 = c;
		return m;
	endfunction

	function automatic res_t diag_res(elem_t a, elem_t b, elem_t c, logic sat);
		res_t r;
		r = '0;
		r.r00 = a; r.r11 = b; r.r22 = c;
		r.saturated = sat;
		return r;
	endfunction

	function automatic res_t singular_res();
		res_t r;
		r = '0;
		r.singular = 1'b1;
		return r;
	endfunction

	function automatic elem_t rand_elem(int kind);
		case (kind)
			0: begin
				return $urandom;
			end
			1: begin
				return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
			end
			2: begin
				return ($urandom_range(0, 3) == 0) ? elem_t'(0)
					: elem_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
			end
			default: begin
				return $signed($urandom_range(0, 64)) - 32;
			end
		endcase
	endfunction

	// Mostly well-conditioned Q16.16 matrices, plus full-range noise, sparse and
	// diagonal shapes, and rank-deficient ones that must come back singular.
	function automatic mat_t rand_matrix();
		mat_t m;
		int kind;
		int shape;
		kind = $urandom_range(0, 3);
		shape = $urandom_range(0, 9);
		m.m00 = rand_elem(kind); m.m01 = rand_elem(kind); m.m02 = rand_elem(kind);
		m.m10 = rand_elem(kind); m.m11 = rand_elem(kind); m.m12 = rand_elem(kind);
		m.m20 = rand_elem(kind); m.m21 = rand_elem(kind); m.m22 = rand_elem(kind);
		if (shape == 0) begin
			m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02;
		end else if (shape == 1) begin
			m = diag(m.m00, m.m11, m.m22);
		end else if (shape == 2) begin
			m.m02 = m.m01; m.m12 = m.m11; m.m22 = m.m21;
		end
		return m;
	endfunction

	// Directed rows: extremes, singular cases and the clamp boundaries.
	initial begin
		mat_t m;
		vec_table.push_back('{'0, 1, singular_res()});
		vec_table.push_back('{diag(ONE, ONE, ONE), 1, diag_res(ONE, ONE, ONE, 1'b0)});
		vec_table.push_back('{{9{EMAX}}, 1, singular_res()});
		vec_table.push_back('{{9{EMIN}}, 1, singular_res()});
		vec_table.push_back('{{9{32'sh5555_aaaa}}, 1, singular_res()});
		// The smallest step inverts far out of range in both directions.
		vec_table.push_back('{diag(1, 1, 1), 1, diag_res(EMAX, EMAX, EMAX, 1'b1)});
		vec_table.push_back('{diag(-1, -1, -1), 1, diag_res(EMIN, EMIN, EMIN, 1'b1)});
		// A quotient of exactly 2^31 clamps when positive but fits when negative.
		vec_table.push_back('{diag(2, 2, 2), 1, diag_res(EMAX, EMAX, EMAX, 1'b1)});
		vec_table.push_back('{diag(-2, -2, -2), 1, diag_res(EMIN, EMIN, EMIN, 1'b0)});
		vec_table.push_back('{diag(ONE, 0, ONE), 1, singular_res()});
		vec_table.push_back('{diag(EMAX, EMAX, EMAX), 0, '0});
		vec_table.push_back('{diag(EMIN, EMIN, EMIN), 0, '0});
		vec_table.push_back('{diag(EMIN, EMAX, -ONE), 0, '0});
		vec_table.push_back('{diag(2 * ONE, -4 * ONE, ONE / 2), 0, '0});
		m = {EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMIN, EMIN, EMAX};
		vec_table.push_back('{m, 0, '0});
		m = {ONE, elem_t'(2 * ONE), elem_t'(3 * ONE), EZERO, ONE, elem_t'(4 * ONE),
			elem_t'(5 * ONE), elem_t'(6 * ONE), EZERO};
		vec_table.push_back('{m, 0, '0});
		m = {EMIN, EUNIT, EZERO, EZERO, EMIN, EUNIT, EUNIT, EZERO, EMIN};
		vec_table.push_back('{m, 0, '0});
		m = {32'shffff_ffff, 32'sh0000_0001, 32'sh7fff_0000, 32'sh8000_ffff,
			32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh0001_0001, 32'shfffe_0000, 32'sh1234_5678};
		vec_table.push_back('{m, 0, '0});
	end

	// Present one word and hold it until the block takes it, then record what
	// it should produce.
	task automatic send_word(mat_t m, bit has_exp, res_t r);
		int gap;
		gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= m;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		inverse_fifo.push_back(has_exp ? r : invert_q16(m));
		words_in++;
	endtask

	initial begin
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 28;
		recv_idle_pct = 63;
		foreach (vec_table[i])
			send_word(vec_table[i].m, vec_table[i].has_exp, vec_table[i].r);

		for (int n = 0; n < N_RANDOM; n++) begin
			// Swap the idling rates after a third, and stop idling after two thirds.
			if (n == N_RANDOM / 3) begin
				send_idle_pct = 63;
				recv_idle_pct = 28;
			end else if (n == 2 * N_RANDOM / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			send_word(rand_matrix(), 0, '0);
		end
		in_ch.valid <= 1'b0;

		while (inverse_fifo.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (errors == 0) begin
			$display("matrix_inverse_3x3 regression: pass");
		end else begin
			$display("matrix_inverse_3x3 regression: fail");
		end
		$finish;
	end

	// Receiver: checks each accepted result word against the oldest expected
	// inverse, then decides the next ready. Once, in the stretch with no idling,
	// it holds off for a long time so that the pipeline fills and stalls input.
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (inverse_fifo.size() == 0) begin
				$display("%0t: result word with none expected: %h", $time, got);
				errors++;
			end else begin
				want = inverse_fifo.pop_front();
				for (int i = 0; i < 9; i++) begin
					if (got[2 + EW * (8 - i) +: EW] !== want[2 + EW * (8 - i) +: EW]) begin
						$display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
							want[2 + EW * (8 - i) +: EW], got[2 + EW * (8 - i) +: EW]);
						errors++;
					end
				end
				if (got.singular !== want.singular) begin
					$display("%0t: singular expected %b actual %b", $time,
						want.singular, got.singular);
					errors++;
				end
				if (got.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						want.saturated, got.saturated);
					errors++;
				end
			end
		end
		if (!hold_done && words_in >= 2 * N_RANDOM / 3 + 40) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYC;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= (hold_left == 1);
		end else begin
			out_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

endmodule
